@@ rtl/core/pcgr_pkg.sv @@
// Shared types, constants and helpers for the PCG32 range generator.
`default_nettype none

package pcgr_pkg;

    localparam logic [63:0] PCG_MULT       = 64'h5851f42d4c957f2d;
    localparam logic [31:0] SEED_RESET     = 32'd1955588763;
    localparam int          QUEUE_DEPTH_DEF = 2;
    localparam logic [31:0] SIGN_BIT       = 32'h80000000;

    // Request type codes as they arrive on the input stream
    localparam logic [2:0] REQ_RAW    = 3'd0;
    localparam logic [2:0] REQ_BOOL   = 3'd1;
    localparam logic [2:0] REQ_FRAC   = 3'd2;
    localparam logic [2:0] REQ_URANGE = 3'd3;
    localparam logic [2:0] REQ_SRANGE = 3'd4;

    typedef enum logic [2:0] {
        K_RAW,
        K_BOOL,
        K_FRAC,
        K_RANGE,
        K_CONST
    } t_kind;

    // Classified request passed from front to back
    typedef struct packed {
        t_kind       kind;
        logic [31:0] low;    // range base, or the constant result
        logic [31:0] span;   // high - low for bounded draws
    } t_cmd;

    typedef enum logic [3:0] {
        BS_SEED,
        BS_IDLE,
        BS_THR,
        BS_DRAW,
        BS_MUL1,
        BS_MUL2,
        BS_UPD,
        BS_MOD,
        BS_DONE
    } t_back_state;

    // XSH-RR output permutation of a 64-bit state
    function automatic logic [31:0] xsh_rr(input logic [63:0] s);
        logic [63:0] x;
        logic [63:0] rr;
        begin
            x  = ((s >> 18) ^ s) >> 27;
            rr = {x[31:0], x[31:0]} >> s[63:59];
            return rr[31:0];
        end
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/pcg32_generator_with_range.sv @@
// PCG32 generator top level: front end, command queue and back end.
`default_nettype none

// PCG32 (XSH-RR) generator with a 64-bit LCG state and range draws. Each request
// transaction on the slave stream yields exactly one result transaction on the
// master stream, in order. An accepted request reaches the back end through the
// front register, then the queue. After reset, and after every seed write, the
// back end reseeds (SEED, DRAW, MUL1, MUL2, UPD) before it takes requests from
// the queue. A raw word, bool or fraction passes through the back end in steps:
// it takes the command, makes one LCG step on a shared 32x32 multiplier (three
// partial products plus the update), and loads the result register.
// A bounded draw adds a bit-serial remainder for the rejection threshold, one
// LCG step per draw (redraws happen while the draw falls below the threshold),
// and another bit-serial remainder for the final reduction. An empty range or
// an unknown type goes from the command straight to the result register. The
// front end and a short queue keep accepting requests while the back end works.
module pcg32_generator_with_range
    import pcgr_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [2:0]  s_tuser,     // req_type
    input  wire logic [63:0] s_tdata,     // range_low, range_high
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,     // result_value
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [31:0] i_cfg_data   // seed_value
);

    t_cmd front_cmd;
    t_cmd queue_cmd;
    logic front_valid;
    logic queue_not_full;
    logic queue_not_empty;
    logic queue_pop;

    pcgr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_tvalid),
        .o_ready      (s_tready),
        .i_req_type   (s_tuser),
        .i_range_low  (s_tdata[31:0]),
        .i_range_high (s_tdata[63:32]),
        .o_cmd_valid  (front_valid),
        .i_cmd_ready  (queue_not_full),
        .o_cmd        (front_cmd)
    );

    pcgr_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (front_valid),
        .o_not_full  (queue_not_full),
        .i_data      (front_cmd),
        .o_not_empty (queue_not_empty),
        .i_pop       (queue_pop),
        .o_data      (queue_cmd)
    );

    pcgr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (queue_not_empty),
        .o_cmd_pop   (queue_pop),
        .i_cmd       (queue_cmd),
        .o_valid     (m_tvalid),
        .i_ready     (m_tready),
        .o_data      (m_tdata)
    );

endmodule

`default_nettype wire

@@ rtl/core/pcgr_front.sv @@
// Front end: accepts request transactions and classifies them into commands.
`default_nettype none

module pcgr_front
    import pcgr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [2:0]  i_req_type,
    input  wire logic [31:0] i_range_low,
    input  wire logic [31:0] i_range_high,
    output logic             o_cmd_valid,
    input  wire logic        i_cmd_ready,
    output t_cmd             o_cmd
);

    logic r_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;

    always_comb begin
        n_cmd.low  = i_range_low;
        n_cmd.span = i_range_high - i_range_low;
        case (i_req_type)
            REQ_RAW:    n_cmd.kind = K_RAW;
            REQ_BOOL:   n_cmd.kind = K_BOOL;
            REQ_FRAC:   n_cmd.kind = K_FRAC;
            REQ_URANGE: n_cmd.kind = (i_range_low >= i_range_high) ? K_CONST : K_RANGE;
            REQ_SRANGE: begin
                // sign-biased compare gives the signed ordering
                n_cmd.kind = ((i_range_low ^ SIGN_BIT) >= (i_range_high ^ SIGN_BIT))
                             ? K_CONST : K_RANGE;
            end
            default: begin
                n_cmd.kind = K_CONST;
                n_cmd.low  = '0;
            end
        endcase
    end

    assign o_ready     = !r_valid || i_cmd_ready;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/pcgr_queue.sv @@
// Short command queue between the front and the back.
`default_nettype none

module pcgr_queue
    import pcgr_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    output logic      o_not_full,
    input  wire t_cmd i_data,
    output logic      o_not_empty,
    input  wire logic i_pop,
    output t_cmd      o_data
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [AW-1:0] LAST  = AW'(QUEUE_DEPTH - 1);
    localparam logic [AW:0]   DEPTH = (AW + 1)'(QUEUE_DEPTH);

    t_cmd          r_mem [QUEUE_DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [AW:0]   r_count;
    logic          do_push;
    logic          do_pop;

    assign o_not_full  = (r_count != DEPTH);
    assign o_not_empty = (r_count != '0);
    assign do_push     = i_push && o_not_full;
    assign do_pop      = i_pop && o_not_empty;
    assign o_data      = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/pcgr_div.sv @@
// Radix-2 restoring remainder unit, one quotient bit per cycle.
`default_nettype none

module pcgr_div
    import pcgr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_dividend,
    input  wire logic [31:0] i_divisor,
    output logic             o_done,
    output logic [31:0]      o_rem
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [31:0] r_rem;
    logic [31:0] r_dvd;
    logic [31:0] r_dvs;
    logic [32:0] trial;
    logic [32:0] diff;

    assign trial  = {r_rem, r_dvd[31]};
    assign diff   = trial - {1'b0, r_dvs};
    assign o_done = r_done;
    assign o_rem  = r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_dvd <= r_dvd << 1;
            // remainder stays below the divisor, so 32 bits hold it
            r_rem <= diff[32] ? trial[31:0] : diff[31:0];
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/pcgr_back.sv @@
// Back end: LCG stepping, rejection sampling, range reduction and result register.
`default_nettype none

module pcgr_back
    import pcgr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_cmd_valid,
    output logic             o_cmd_pop,
    input  wire t_cmd        i_cmd,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_data
);

    t_back_state r_fsm;
    t_back_state n_fsm;

    logic [31:0] r_seed;
    logic [63:0] r_state;
    logic [63:0] r_acc;
    logic [63:0] r_prod;
    logic [31:0] r_word;
    logic [31:0] r_thr;
    logic [31:0] r_res;
    logic        r_seeding;
    t_cmd        r_cmd;
    logic        r_out_valid;
    logic [31:0] r_out_data;

    logic [32:0] inc;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic        cfg_take;
    logic        cmd_take;
    logic        accept_draw;
    logic        out_free;
    logic        div_start;
    logic [31:0] div_dividend;
    logic [31:0] div_divisor;
    logic        div_done;
    logic [31:0] div_rem;

    assign inc         = {r_seed, 1'b1};
    assign o_cfg_ready = (r_fsm == BS_IDLE);
    assign cfg_take    = o_cfg_ready && i_cfg_valid;
    assign cmd_take    = (r_fsm == BS_IDLE) && !i_cfg_valid && i_cmd_valid;
    assign o_cmd_pop   = cmd_take;
    assign accept_draw = (r_word >= r_thr);
    assign out_free    = !r_out_valid || i_ready;
    assign o_valid     = r_out_valid;
    assign o_data      = r_out_data;

    assign div_start = (cmd_take && i_cmd.kind == K_RANGE)
                    || (r_fsm == BS_UPD && !r_seeding && r_cmd.kind == K_RANGE
                        && accept_draw);
    // threshold is (2^32 - span) mod span; a kept draw is reduced mod span
    assign div_dividend = (r_fsm == BS_IDLE) ? (32'd0 - i_cmd.span) : r_word;
    assign div_divisor  = (r_fsm == BS_IDLE) ? i_cmd.span : r_cmd.span;

    pcgr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    // 64x64 low product from three 32x32 partial products
    always_comb begin
        case (r_fsm)
            BS_MUL1: begin
                mul_a = r_state[63:32];
                mul_b = PCG_MULT[31:0];
            end
            BS_MUL2: begin
                mul_a = r_state[31:0];
                mul_b = PCG_MULT[63:32];
            end
            default: begin
                mul_a = r_state[31:0];
                mul_b = PCG_MULT[31:0];
            end
        endcase
    end

    always_comb begin
        n_fsm = r_fsm;
        case (r_fsm)
            BS_SEED: n_fsm = BS_DRAW;
            BS_IDLE: begin
                if (cfg_take) begin
                    n_fsm = BS_SEED;
                end else if (cmd_take) begin
                    case (i_cmd.kind)
                        K_RANGE: n_fsm = BS_THR;
                        K_CONST: n_fsm = BS_DONE;
                        default: n_fsm = BS_DRAW;
                    endcase
                end
            end
            BS_THR:  n_fsm = div_done ? BS_DRAW : BS_THR;
            BS_DRAW: n_fsm = BS_MUL1;
            BS_MUL1: n_fsm = BS_MUL2;
            BS_MUL2: n_fsm = BS_UPD;
            BS_UPD: begin
                if (r_seeding) begin
                    n_fsm = BS_IDLE;
                end else if (r_cmd.kind == K_RANGE) begin
                    n_fsm = accept_draw ? BS_MOD : BS_DRAW;
                end else begin
                    n_fsm = BS_DONE;
                end
            end
            BS_MOD:  n_fsm = div_done ? BS_DONE : BS_MOD;
            BS_DONE: n_fsm = out_free ? BS_IDLE : BS_DONE;
            default: n_fsm = BS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm <= BS_SEED;
        end else begin
            r_fsm <= n_fsm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed      <= SEED_RESET;
            r_seeding   <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_take) begin
                r_seed <= i_cfg_data;
            end
            if (r_fsm == BS_SEED) begin
                r_seeding <= 1'b1;
            end else if (cmd_take) begin
                r_seeding <= 1'b0;
            end
            if (r_fsm == BS_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(mul_a) * 64'(mul_b);
        case (r_fsm)
            BS_SEED: begin
                // zero state stepped once is the increment, then the seed is added
                r_state <= {31'b0, inc} + {32'b0, r_seed};
            end
            BS_IDLE: begin
                if (cmd_take) begin
                    r_cmd <= i_cmd;
                    r_res <= i_cmd.low;
                end
            end
            BS_THR: begin
                if (div_done) begin
                    r_thr <= div_rem;
                end
            end
            BS_DRAW: r_word <= xsh_rr(r_state);
            BS_MUL1: r_acc <= r_prod + {31'b0, inc};
            BS_MUL2: r_acc[63:32] <= r_acc[63:32] + r_prod[31:0];
            BS_UPD: begin
                r_state <= {r_acc[63:32] + r_prod[31:0], r_acc[31:0]};
                case (r_cmd.kind)
                    K_BOOL:  r_res <= {31'b0, r_word[31]};
                    K_FRAC:  r_res <= {8'b0, r_word[31:8]};
                    default: r_res <= r_word;
                endcase
            end
            BS_MOD: begin
                if (div_done) begin
                    r_res <= r_cmd.low + div_rem;
                end
            end
            BS_DONE: begin
                if (out_free) begin
                    r_out_data <= r_res;
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire
